// ----- rtl/olte_pkg.sv -----
// ----------------------------------------------------------------------------
// olte_pkg
// Types and constants shared by the ordered list table engine.
// ----------------------------------------------------------------------------
package olte_pkg;

	localparam int DEPTH  = 64;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = IDX_W + 1;
	localparam int DATA_W = 32;
	localparam int CMD_W  = 3;
	localparam int STAT_W = 2;

	typedef enum logic [CMD_W-1:0] {
		OP_INSERT       = 3'd0,
		OP_APPEND       = 3'd1,
		OP_DELETE_AT    = 3'd2,
		OP_DELETE_VALUE = 3'd3,
		OP_INDEX_OF     = 3'd4,
		OP_SWAP         = 3'd5,
		OP_READ         = 3'd6,
		OP_CLEAR        = 3'd7
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 2'd0,
		ST_INVALID   = 2'd1,
		ST_OVERFLOW  = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		RD_PTR, RD_PTR_M1, RD_PTR_P1, RD_PTR_M2, RD_PTR_P2, RD_POS, RD_POS2
	} rd_sel_t;

	typedef enum logic [1:0] {
		WA_PTR, WA_POS, WA_POS2
	} wa_sel_t;

	typedef enum logic [1:0] {
		WD_RDATA, WD_VALUE, WD_TMP
	} wd_sel_t;

	typedef enum logic [2:0] {
		PTR_HOLD, PTR_ZERO, PTR_COUNT, PTR_POS, PTR_INC, PTR_DEC
	} ptr_op_t;

	typedef enum logic [1:0] {
		CNT_HOLD, CNT_INC, CNT_DEC, CNT_CLR
	} cnt_op_t;

	typedef enum logic [3:0] {
		S_IDLE, S_CHECK, S_UP_PRIME, S_UP, S_PUT, S_DN_PRIME, S_DN,
		S_FIND_PRIME, S_FIND, S_SW_RD2, S_SW_WR1, S_SW_WR2, S_RD_CAP, S_POST
	} state_t;

	typedef struct packed {
		logic    load;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    wr_en;
		wa_sel_t wa_sel;
		wd_sel_t wd_sel;
		ptr_op_t ptr_op;
		cnt_op_t cnt_op;
		logic    save_tmp;
		logic    status_we;
		status_t status;
		logic    found_we;
		logic    rdval_we;
		logic    post;
	} dp_cmd_t;

	typedef struct packed {
		op_t  op;
		logic ins_bad;
		logic full;
		logic pos_bad;
		logic pos2_bad;
		logic same_pos;
		logic empty;
		logic ptr_gt_idx;
		logic ptr_gt_idx1;
		logic ptr1_lt_cnt;
		logic ptr2_lt_cnt;
		logic match;
	} dp_stat_t;

endpackage

// ----- rtl/olte_if.sv -----
// ----------------------------------------------------------------------------
// olte_if
// Request and response channels of the ordered list table engine.
// ----------------------------------------------------------------------------
interface olte_req_if import olte_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  cmd;
	logic [CNT_W-1:0]  position;
	logic [IDX_W-1:0]  other_position;
	logic [DATA_W-1:0] entry_value;

	modport source (output valid, output cmd, output position, output other_position,
		output entry_value, input ready);
	modport sink (input valid, input cmd, input position, input other_position,
		input entry_value, output ready);
endinterface

interface olte_rsp_if import olte_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [STAT_W-1:0] status;
	logic [IDX_W-1:0]  found_position;
	logic [DATA_W-1:0] read_value;
	logic [CNT_W-1:0]  list_length;

	modport source (output valid, output status, output found_position,
		output read_value, output list_length, input ready);
	modport sink (input valid, input status, input found_position,
		input read_value, input list_length, output ready);
endinterface

// ----- rtl/olte_dp.sv -----
// ----------------------------------------------------------------------------
// olte_dp
// Datapath: entry memory, length, walk pointer, compares and result registers.
// ----------------------------------------------------------------------------
module olte_dp import olte_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  dp_cmd_t           cmd,
	output dp_stat_t          stat,
	input  logic [CMD_W-1:0]  req_cmd,
	input  logic [CNT_W-1:0]  req_position,
	input  logic [IDX_W-1:0]  req_other_position,
	input  logic [DATA_W-1:0] req_entry_value,
	input  logic              cfg_we,
	input  logic [CNT_W-1:0]  cfg_wdata,
	output logic [STAT_W-1:0] rsp_status,
	output logic [IDX_W-1:0]  rsp_found_position,
	output logic [DATA_W-1:0] rsp_read_value,
	output logic [CNT_W-1:0]  rsp_list_length
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rdata_q;
	logic [DATA_W-1:0] tmp_q;
	logic [DATA_W-1:0] value_q;
	op_t               op_q;
	logic [CNT_W-1:0]  pos_q;
	logic [IDX_W-1:0]  pos2_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  max_q;
	logic [CNT_W-1:0]  ptr_q;
	status_t           status_q;
	logic [IDX_W-1:0]  found_q;
	logic [DATA_W-1:0] rdval_q;
	logic [STAT_W-1:0] out_status_q;
	logic [IDX_W-1:0]  out_found_q;
	logic [DATA_W-1:0] out_rdval_q;
	logic [CNT_W-1:0]  out_len_q;

	logic [CNT_W-1:0]  idx;
	logic [CNT_W:0]    ptr_w;
	logic [CNT_W:0]    cnt_w;
	logic [CNT_W:0]    idx_w;
	logic [IDX_W-1:0]  ptr_a;
	logic [IDX_W-1:0]  rd_addr;
	logic [IDX_W-1:0]  wr_addr;
	logic [DATA_W-1:0] wr_data;

	// insert position
	assign idx   = (op_q == OP_APPEND) ? count_q : pos_q;
	assign ptr_w = {1'b0, ptr_q};
	assign cnt_w = {1'b0, count_q};
	assign idx_w = {1'b0, idx};
	assign ptr_a = ptr_q[IDX_W-1:0];

	always_comb begin
		stat.op          = op_q;
		stat.ins_bad     = idx > count_q;
		stat.full        = (count_q >= CNT_W'(DEPTH)) || ((max_q != '0) && (count_q >= max_q));
		stat.pos_bad     = pos_q >= count_q;
		stat.pos2_bad    = {1'b0, pos2_q} >= count_q;
		stat.same_pos    = pos_q == {1'b0, pos2_q};
		stat.empty       = count_q == '0;
		stat.ptr_gt_idx  = ptr_q > idx;
		stat.ptr_gt_idx1 = ptr_w > (idx_w + (CNT_W+1)'(1));
		stat.ptr1_lt_cnt = (ptr_w + (CNT_W+1)'(1)) < cnt_w;
		stat.ptr2_lt_cnt = (ptr_w + (CNT_W+1)'(2)) < cnt_w;
		stat.match       = rdata_q == value_q;
	end

	always_comb begin
		case (cmd.rd_sel)
			RD_PTR:    rd_addr = ptr_a;
			RD_PTR_M1: rd_addr = ptr_a - IDX_W'(1);
			RD_PTR_P1: rd_addr = ptr_a + IDX_W'(1);
			RD_PTR_M2: rd_addr = ptr_a - IDX_W'(2);
			RD_PTR_P2: rd_addr = ptr_a + IDX_W'(2);
			RD_POS:    rd_addr = pos_q[IDX_W-1:0];
			RD_POS2:   rd_addr = pos2_q;
			default:   rd_addr = ptr_a;
		endcase
	end

	always_comb begin
		case (cmd.wa_sel)
			WA_PTR:  wr_addr = ptr_a;
			WA_POS:  wr_addr = pos_q[IDX_W-1:0];
			WA_POS2: wr_addr = pos2_q;
			default: wr_addr = ptr_a;
		endcase
	end

	always_comb begin
		case (cmd.wd_sel)
			WD_RDATA: wr_data = rdata_q;
			WD_VALUE: wr_data = value_q;
			WD_TMP:   wr_data = tmp_q;
			default:  wr_data = rdata_q;
		endcase
	end

	// entry memory
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			max_q   <= '0;
			ptr_q   <= '0;
		end else begin
			if (cfg_we) begin
				max_q <= cfg_wdata;
			end
			case (cmd.cnt_op)
				CNT_INC: count_q <= count_q + CNT_W'(1);
				CNT_DEC: count_q <= count_q - CNT_W'(1);
				CNT_CLR: count_q <= '0;
				default: count_q <= count_q;
			endcase
			case (cmd.ptr_op)
				PTR_ZERO:  ptr_q <= '0;
				PTR_COUNT: ptr_q <= count_q;
				PTR_POS:   ptr_q <= pos_q;
				PTR_INC:   ptr_q <= ptr_q + CNT_W'(1);
				PTR_DEC:   ptr_q <= ptr_q - CNT_W'(1);
				default:   ptr_q <= ptr_q;
			endcase
		end
	end

	// request fields and result collection
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= op_t'(req_cmd);
			pos_q    <= req_position;
			pos2_q   <= req_other_position;
			value_q  <= req_entry_value;
			status_q <= ST_OK;
			found_q  <= '0;
			rdval_q  <= '0;
		end else begin
			if (cmd.status_we) begin
				status_q <= cmd.status;
			end
			if (cmd.found_we) begin
				found_q <= ptr_a;
			end
			if (cmd.rdval_we) begin
				rdval_q <= rdata_q;
			end
		end
		if (cmd.save_tmp) begin
			tmp_q <= rdata_q;
		end
		if (cmd.post) begin
			out_status_q <= status_q;
			out_found_q  <= found_q;
			out_rdval_q  <= rdval_q;
			out_len_q    <= count_q;
		end
	end

	assign rsp_status         = out_status_q;
	assign rsp_found_position = out_found_q;
	assign rsp_read_value     = out_rdval_q;
	assign rsp_list_length    = out_len_q;

endmodule

// ----- rtl/olte_ctrl.sv -----
// ----------------------------------------------------------------------------
// olte_ctrl
// Controller: sequences requests, one datapath step per cycle unless stalled.
// ----------------------------------------------------------------------------
module olte_ctrl import olte_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.post) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				state_d = S_POST;
				case (stat.op)
					OP_INSERT, OP_APPEND: begin
						if (stat.ins_bad) begin
							cmd.status_we = 1'b1;
							cmd.status    = ST_INVALID;
						end else if (stat.full) begin
							cmd.status_we = 1'b1;
							cmd.status    = ST_OVERFLOW;
						end else begin
							cmd.ptr_op = PTR_COUNT;
							state_d    = S_UP_PRIME;
						end
					end
					OP_DELETE_AT: begin
						if (stat.pos_bad) begin
							cmd.status_we = 1'b1;
							cmd.status    = ST_INVALID;
						end else begin
							cmd.ptr_op = PTR_POS;
							state_d    = S_DN_PRIME;
						end
					end
					OP_DELETE_VALUE, OP_INDEX_OF: begin
						if (stat.empty) begin
							cmd.status_we = 1'b1;
							cmd.status    = ST_NOT_FOUND;
						end else begin
							cmd.ptr_op = PTR_ZERO;
							state_d    = S_FIND_PRIME;
						end
					end
					OP_SWAP: begin
						if (stat.pos_bad || stat.pos2_bad) begin
							cmd.status_we = 1'b1;
							cmd.status    = ST_INVALID;
						end else if (!stat.same_pos) begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = RD_POS;
							state_d    = S_SW_RD2;
						end
					end
					OP_READ: begin
						if (stat.pos_bad) begin
							cmd.status_we = 1'b1;
							cmd.status    = ST_INVALID;
						end else begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = RD_POS;
							state_d    = S_RD_CAP;
						end
					end
					default: begin
						cmd.cnt_op = CNT_CLR;
					end
				endcase
			end
			S_UP_PRIME: begin
				if (stat.ptr_gt_idx) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_PTR_M1;
					state_d    = S_UP;
				end else begin
					state_d = S_PUT;
				end
			end
			S_UP: begin
				cmd.wr_en  = 1'b1;
				cmd.wa_sel = WA_PTR;
				cmd.wd_sel = WD_RDATA;
				cmd.ptr_op = PTR_DEC;
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_PTR_M2;
				if (!stat.ptr_gt_idx1) begin
					state_d = S_PUT;
				end
			end
			S_PUT: begin
				cmd.wr_en  = 1'b1;
				cmd.wa_sel = WA_PTR;
				cmd.wd_sel = WD_VALUE;
				cmd.cnt_op = CNT_INC;
				state_d    = S_POST;
			end
			S_DN_PRIME: begin
				if (stat.ptr1_lt_cnt) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_PTR_P1;
					state_d    = S_DN;
				end else begin
					cmd.cnt_op = CNT_DEC;
					state_d    = S_POST;
				end
			end
			S_DN: begin
				cmd.wr_en  = 1'b1;
				cmd.wa_sel = WA_PTR;
				cmd.wd_sel = WD_RDATA;
				cmd.ptr_op = PTR_INC;
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_PTR_P2;
				if (!stat.ptr2_lt_cnt) begin
					cmd.cnt_op = CNT_DEC;
					state_d    = S_POST;
				end
			end
			S_FIND_PRIME: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_PTR;
				state_d    = S_FIND;
			end
			S_FIND: begin
				if (stat.match) begin
					cmd.found_we = 1'b1;
					state_d      = (stat.op == OP_DELETE_VALUE) ? S_DN_PRIME : S_POST;
				end else if (stat.ptr1_lt_cnt) begin
					cmd.ptr_op = PTR_INC;
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_PTR_P1;
				end else begin
					cmd.status_we = 1'b1;
					cmd.status    = ST_NOT_FOUND;
					state_d       = S_POST;
				end
			end
			S_SW_RD2: begin
				cmd.save_tmp = 1'b1;
				cmd.rd_en    = 1'b1;
				cmd.rd_sel   = RD_POS2;
				state_d      = S_SW_WR1;
			end
			S_SW_WR1: begin
				cmd.wr_en  = 1'b1;
				cmd.wa_sel = WA_POS;
				cmd.wd_sel = WD_RDATA;
				state_d    = S_SW_WR2;
			end
			S_SW_WR2: begin
				cmd.wr_en  = 1'b1;
				cmd.wa_sel = WA_POS2;
				cmd.wd_sel = WD_TMP;
				state_d    = S_POST;
			end
			S_RD_CAP: begin
				cmd.rdval_we = 1'b1;
				state_d      = S_POST;
			end
			S_POST: begin
				if (out_free) begin
					cmd.post = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ----- rtl/ordered_list_table_engine.sv -----
// ----------------------------------------------------------------------------
// ordered_list_table_engine
// Bounded ordered list with insert, append, delete, search, swap, read, clear.
// ----------------------------------------------------------------------------
// one request at a time; insert, delete_at, delete_value and index_of walk the list,
// append, read, swap and clear do not
// the list walk moves one entry per cycle through one read and one write port
// the next request is taken at the edge after the response enters the output register
// arst_n clears the length, max_entries and the controller; entries are not cleared
module ordered_list_table_engine import olte_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	olte_req_if.sink         req,
	olte_rsp_if.source       rsp,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	olte_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	olte_dp u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.stat               (stat),
		.req_cmd            (req.cmd),
		.req_position       (req.position),
		.req_other_position (req.other_position),
		.req_entry_value    (req.entry_value),
		.cfg_we             (cfg_we),
		.cfg_wdata          (cfg_wdata),
		.rsp_status         (rsp.status),
		.rsp_found_position (rsp.found_position),
		.rsp_read_value     (rsp.read_value),
		.rsp_list_length    (rsp.list_length)
	);

endmodule

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ordered list table engine. Requests are built
// per test (directed corner cases, a full list, length limits, a long
// response stall and random command streams), a local copy of the list
// predicts every response, and a checker compares each response field by
// field against the oldest prediction. Both channels idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
	import olte_pkg::*;

	localparam int QUIET_LIMIT = 4000;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 2 * DEPTH + 8;

	typedef struct {
		status_t           status;
		logic [IDX_W-1:0]  found;
		logic [DATA_W-1:0] rdval;
		logic [CNT_W-1:0]  length;
	} answer_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CNT_W-1:0] cfg_wdata;

	olte_req_if req_ch ();
	olte_rsp_if rsp_ch ();

	ordered_list_table_engine dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #2 clk = ~clk;

	logic [DATA_W-1:0] list_mem [DEPTH];
	int                list_len = 0;
	int                list_limit = 0;
	answer_t           pending_answers [$];
	int                mismatches = 0;
	bit                stall_en = 1'b1;
	bit                hold_start = 1'b0;
	int                quiet_cycles = 0;
	logic [DATA_W-1:0] value_pool [10];

	function automatic int list_find(logic [DATA_W-1:0] val);
		for (int i = 0; i < list_len; i++)
			if (list_mem[i] == val)
				return i;
		return -1;
	endfunction

	function automatic void list_drop(int at);
		for (int i = at; i + 1 < list_len; i++)
			list_mem[i] = list_mem[i + 1];
		list_len--;
	endfunction

	function automatic status_t list_put(int at, logic [DATA_W-1:0] val);
		if (at > list_len)
			return ST_INVALID;
		if (list_len >= DEPTH || (list_limit != 0 && list_len >= list_limit))
			return ST_OVERFLOW;
		for (int i = list_len; i > at; i--)
			list_mem[i] = list_mem[i - 1];
		list_mem[at] = val;
		list_len++;
		return ST_OK;
	endfunction

	function automatic answer_t list_apply(op_t op, int pos, int pos2, logic [DATA_W-1:0] val);
		answer_t a;
		int hit;
		logic [DATA_W-1:0] t;
		a.status = ST_OK;
		a.found = '0;
		a.rdval = '0;
		case (op)
			OP_INSERT: a.status = list_put(pos, val);
			OP_APPEND: a.status = list_put(list_len, val);
			OP_DELETE_AT: begin
				if (pos >= list_len)
					a.status = ST_INVALID;
				else
					list_drop(pos);
			end
			OP_DELETE_VALUE, OP_INDEX_OF: begin
				hit = list_find(val);
				if (hit < 0) begin
					a.status = ST_NOT_FOUND;
				end else begin
					a.found = hit[IDX_W-1:0];
					if (op == OP_DELETE_VALUE)
						list_drop(hit);
				end
			end
			OP_SWAP: begin
				if (pos >= list_len || pos2 >= list_len) begin
					a.status = ST_INVALID;
				end else begin
					t = list_mem[pos];
					list_mem[pos] = list_mem[pos2];
					list_mem[pos2] = t;
				end
			end
			OP_READ: begin
				if (pos >= list_len)
					a.status = ST_INVALID;
				else
					a.rdval = list_mem[pos];
			end
			default: list_len = 0;
		endcase
		a.length = list_len[CNT_W-1:0];
		return a;
	endfunction

	// response side: random stalls, plus a long hold-off on request
	initial begin : rsp_ready_drive
		int hold_left;
		hold_left = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_start) begin
				hold_left = HOLD_CYCLES;
				hold_start = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= !(stall_en && $urandom_range(0, 99) < 27);
			end
		end
	end

	always @(posedge clk) begin : check_answers
		answer_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_answers.size() == 0) begin
				$error("response with no request outstanding");
				mismatches++;
			end else begin
				want = pending_answers.pop_front();
				if (rsp_ch.status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, rsp_ch.status);
					mismatches++;
				end
				if (rsp_ch.found_position !== want.found) begin
					$error("found_position: expected %0d, actual %0d", want.found,
						rsp_ch.found_position);
					mismatches++;
				end
				if (rsp_ch.read_value !== want.rdval) begin
					$error("read_value: expected %h, actual %h", want.rdval,
						rsp_ch.read_value);
					mismatches++;
				end
				if (rsp_ch.list_length !== want.length) begin
					$error("list_length: expected %0d, actual %0d", want.length,
						rsp_ch.list_length);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	task automatic send_request(op_t op, int pos, int pos2, logic [DATA_W-1:0] val);
		while (stall_en && $urandom_range(0, 99) < 27) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.cmd <= op;
		req_ch.position <= pos[CNT_W-1:0];
		req_ch.other_position <= pos2[IDX_W-1:0];
		req_ch.entry_value <= val;
		do @(posedge clk); while (!req_ch.ready);
		pending_answers.push_back(list_apply(op, pos, pos2, val));
	endtask

	task automatic settle();
		req_ch.valid <= 1'b0;
		while (pending_answers.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_max_entries(int limit);
		settle();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= limit[CNT_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		list_limit = limit;
	endtask

	task automatic test_directed();
		write_max_entries(0);
		send_request(OP_READ, 0, 0, 32'h0);
		send_request(OP_DELETE_AT, 0, 0, 32'h0);
		send_request(OP_DELETE_VALUE, 0, 0, 32'h0);
		send_request(OP_INDEX_OF, 0, 0, 32'hFFFF_FFFF);
		send_request(OP_SWAP, 0, 0, 32'h0);
		send_request(OP_INSERT, 1, 0, 32'h1111_1111);
		send_request(OP_APPEND, 0, 0, 32'h0000_0000);
		send_request(OP_APPEND, 64, 63, 32'hFFFF_FFFF);
		send_request(OP_INSERT, 0, 0, 32'hA5A5_5A5A);
		send_request(OP_INSERT, 3, 0, 32'h1234_5678);
		send_request(OP_INSERT, 64, 0, 32'h5555_AAAA);
		send_request(OP_INDEX_OF, 0, 0, 32'hFFFF_FFFF);
		send_request(OP_SWAP, 0, 3, 32'h0);
		send_request(OP_SWAP, 1, 1, 32'h0);
		send_request(OP_SWAP, 0, 63, 32'h0);
		send_request(OP_READ, 0, 0, 32'h0);
		send_request(OP_READ, 3, 0, 32'h0);
		send_request(OP_READ, 64, 0, 32'h0);
		send_request(OP_DELETE_VALUE, 0, 0, 32'h0000_0000);
		send_request(OP_DELETE_AT, 2, 0, 32'h0);
		send_request(OP_DELETE_AT, 5, 0, 32'h0);
		send_request(OP_INDEX_OF, 0, 0, 32'h7777_7777);
		send_request(OP_CLEAR, 0, 0, 32'h0);
		send_request(OP_READ, 0, 0, 32'h0);
		settle();
	endtask

	task automatic test_full_list();
		write_max_entries(DEPTH);
		for (int i = 0; i < DEPTH; i++)
			send_request(OP_APPEND, 0, 0, $urandom());
		send_request(OP_APPEND, 0, 0, 32'hDEAD_0001);
		send_request(OP_INSERT, DEPTH, 0, 32'hDEAD_0002);
		send_request(OP_INSERT, 0, 0, 32'hDEAD_0003);
		send_request(OP_INDEX_OF, 0, 0, list_mem[DEPTH-1]);
		send_request(OP_READ, DEPTH - 1, 0, 32'h0);
		send_request(OP_SWAP, 0, DEPTH - 1, 32'h0);
		send_request(OP_DELETE_VALUE, 0, 0, list_mem[DEPTH-1]);
		send_request(OP_DELETE_AT, 0, 0, 32'h0);
		write_max_entries(0);
		send_request(OP_INSERT, 0, 0, 32'h0F0F_0F0F);
		send_request(OP_APPEND, 0, 0, 32'hF0F0_F0F0);
		send_request(OP_APPEND, 0, 0, 32'h0000_0001);
		send_request(OP_DELETE_AT, DEPTH - 1, 0, 32'h0);
		send_request(OP_CLEAR, 0, 0, 32'h0);
		settle();
	endtask

	task automatic test_length_limit();
		write_max_entries(3);
		for (int i = 0; i < 4; i++)
			send_request(OP_APPEND, 0, 0, $urandom());
		send_request(OP_INSERT, 2, 0, 32'h0000_0002);
		send_request(OP_INSERT, 5, 0, 32'h0000_0005);
		write_max_entries(1);
		send_request(OP_APPEND, 0, 0, 32'h0000_0006);
		send_request(OP_DELETE_AT, 0, 0, 32'h0);
		send_request(OP_INSERT, 0, 0, 32'h0000_0007);
		send_request(OP_READ, 1, 0, 32'h0);
		send_request(OP_CLEAR, 0, 0, 32'h0);
		send_request(OP_APPEND, 0, 0, 32'h0000_0008);
		send_request(OP_APPEND, 0, 0, 32'h0000_0009);
		write_max_entries(0);
	endtask

	task automatic test_response_stall();
		hold_start = 1'b1;
		for (int i = 0; i < 10; i++) begin
			if (i % 3 == 2)
				send_request(OP_READ, $urandom_range(0, list_len), 0, 32'h0);
			else
				send_request(OP_APPEND, 0, 0, $urandom());
		end
		settle();
	endtask

	task automatic test_random(int total);
		int per_phase;
		int pick;
		int pos;
		int pos2;
		op_t op;
		logic [DATA_W-1:0] val;
		per_phase = total / 7;
		for (int phase = 0; phase < 7; phase++) begin
			for (int k = 0; k < 8; k++)
				value_pool[k] = $urandom();
			value_pool[8] = '0;
			value_pool[9] = '1;
			case (phase)
				0: write_max_entries(0);
				1: write_max_entries(DEPTH);
				2: write_max_entries($urandom_range(2, 16));
				3: write_max_entries($urandom_range(0, DEPTH));
				4: write_max_entries(1);
				5: begin
					settle();
					if (list_len > 1)
						write_max_entries($urandom_range(1, list_len - 1));
					else
						write_max_entries($urandom_range(1, 8));
				end
				default: write_max_entries(0);
			endcase
			// one phase runs without any idle cycles
			stall_en = (phase != 3);
			for (int n = 0; n < per_phase; n++) begin
				pick = $urandom_range(0, 99);
				if (list_len < 4 && pick < 40)
					op = OP_APPEND;
				else if (pick < 18)
					op = OP_INSERT;
				else if (pick < 35)
					op = OP_APPEND;
				else if (pick < 47)
					op = OP_DELETE_AT;
				else if (pick < 57)
					op = OP_DELETE_VALUE;
				else if (pick < 69)
					op = OP_INDEX_OF;
				else if (pick < 79)
					op = OP_SWAP;
				else if (pick < 96)
					op = OP_READ;
				else
					op = OP_CLEAR;
				if ($urandom_range(0, 99) < 85)
					pos = $urandom_range(0, list_len);
				else
					pos = $urandom_range(0, DEPTH);
				if ($urandom_range(0, 99) < 85)
					pos2 = $urandom_range(0, (list_len > 0) ? list_len - 1 : 0);
				else
					pos2 = $urandom_range(0, DEPTH - 1);
				if ($urandom_range(0, 99) < 70)
					val = value_pool[$urandom_range(0, 9)];
				else
					val = $urandom();
				send_request(op, pos, pos2, val);
			end
			stall_en = 1'b1;
		end
		settle();
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		req_ch.valid <= 1'b0;
		req_ch.cmd <= OP_CLEAR;
		req_ch.position <= '0;
		req_ch.other_position <= '0;
		req_ch.entry_value <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_full_list();
		test_length_limit();
		test_response_stall();
		test_random(924);

		settle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_answers.size() == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
